[rtl/core/pncq_pkg.sv]
// shared types and constants for the palette nearest color quantizer
package pncq_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 64;
   localparam int INDEX_SLOTS             = 64;
   localparam int INDEX_WIDTH             = 6;
   localparam int COUNT_WIDTH             = 7;
   localparam int CHAN_WIDTH              = 8;
   localparam int ERR_WIDTH               = CHAN_WIDTH + 1;
   localparam int SQ_WIDTH                = 2 * CHAN_WIDTH;
   localparam int DIST_WIDTH              = SQ_WIDTH + 2;
   localparam int COLOR_WIDTH             = 3 * CHAN_WIDTH;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_QUANTIZE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
   } color_type;

endpackage

[rtl/core/palette_nearest_color_quantizer.sv]
// palette nearest color quantizer: palette memory and sequential nearest-entry search
//
// req channel: opcode load writes red/green/blue into palette slot entry_index
// (slots at or beyond PALETTE_ENTRIES are dropped); opcode quantize searches
// entries 0 to palette_count-1 for the least squared RGB distance, lowest index
// on ties, and returns one rsp transaction with the index, its color and the
// pixel-minus-palette error per channel. a load gives no response.
// csr_wr_en writes palette_count (reset 1, zero acts as 1, values above the
// store size saturate).
// after a load the next transaction may follow at once.
// a quantize of n active entries occupies the block for the whole search:
// one memory read per entry on the single read port, two pipeline stages
// (squares, then sum and compare) and a final state to form the response.
// req_stall is high for the whole search; a finished response sits in the
// output register, so a new transaction is taken while rsp_stall holds it,
// and a further search waits in its final cycle until the register frees up.
// reset (synchronous) clears the handshake state and palette_count; the
// palette contents are undefined until loaded.
module palette_nearest_color_quantizer
   import pncq_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [INDEX_WIDTH-1:0]        req_entry_index,
   input  logic [CHAN_WIDTH-1:0]         req_red,
   input  logic [CHAN_WIDTH-1:0]         req_green,
   input  logic [CHAN_WIDTH-1:0]         req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [INDEX_WIDTH-1:0]        rsp_best_index,
   output logic [CHAN_WIDTH-1:0]         rsp_out_red,
   output logic [CHAN_WIDTH-1:0]         rsp_out_green,
   output logic [CHAN_WIDTH-1:0]         rsp_out_blue,
   output logic signed [ERR_WIDTH-1:0]   rsp_err_red,
   output logic signed [ERR_WIDTH-1:0]   rsp_err_green,
   output logic signed [ERR_WIDTH-1:0]   rsp_err_blue,
   input  logic                          csr_wr_en,
   input  logic [COUNT_WIDTH-1:0]        csr_wr_data
);

   localparam int AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int LIM = (PALETTE_ENTRIES < INDEX_SLOTS) ? PALETTE_ENTRIES : INDEX_SLOTS;

   color_type                palette_mem_ff [PALETTE_ENTRIES];

   state_type                state_ff, state_in;
   logic [COUNT_WIDTH-1:0]   palette_count_ff;
   color_type                px_ff, px_in;
   logic [INDEX_WIDTH-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [INDEX_WIDTH-1:0]   last_ff, last_in;
   color_type                rd_data_ff;
   logic                     v1_ff, l1_ff;
   logic [INDEX_WIDTH-1:0]   idx1_ff;
   logic                     v2_ff, l2_ff;
   logic [INDEX_WIDTH-1:0]   idx2_ff;
   color_type                color2_ff;
   logic [SQ_WIDTH-1:0]      sq_r_ff, sq_g_ff, sq_b_ff;
   logic                     first_ff, first_in;
   logic [DIST_WIDTH-1:0]    best_dist_ff, best_dist_in;
   logic [INDEX_WIDTH-1:0]   best_idx_ff, best_idx_in;
   color_type                best_color_ff, best_color_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_load;

   logic                     req_take;
   logic [AW+INDEX_WIDTH-1:0] wr_ext, rd_ext;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [COUNT_WIDTH-1:0]   active_n;
   logic [CHAN_WIDTH-1:0]    dr, dg, db;
   logic [DIST_WIDTH-1:0]    cand_dist;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign wr_ext  = {{AW{1'b0}}, req_entry_index};
   assign wr_addr = wr_ext[AW-1:0];
   assign wr_en   = req_take && (req_opcode == OP_LOAD) &&
                    (wr_ext < (AW+INDEX_WIDTH)'(PALETTE_ENTRIES));
   assign rd_ext  = {{AW{1'b0}}, rd_cnt_ff};
   assign rd_addr = rd_ext[AW-1:0];

   always_comb begin
      if (palette_count_ff == '0) begin
         active_n = COUNT_WIDTH'(1);
      end else if (palette_count_ff > COUNT_WIDTH'(LIM)) begin
         active_n = COUNT_WIDTH'(LIM);
      end else begin
         active_n = palette_count_ff;
      end
   end

   // palette memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem_ff[wr_addr] <= color_type'({req_red, req_green, req_blue});
      end
      rd_data_ff <= palette_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_count_ff <= COUNT_WIDTH'(1);
      end else if (csr_wr_en) begin
         palette_count_ff <= csr_wr_data;
      end
   end

   // squares stage
   always_comb begin
      dr = (rd_data_ff.red >= px_ff.red) ? rd_data_ff.red - px_ff.red
                                         : px_ff.red - rd_data_ff.red;
      dg = (rd_data_ff.green >= px_ff.green) ? rd_data_ff.green - px_ff.green
                                             : px_ff.green - rd_data_ff.green;
      db = (rd_data_ff.blue >= px_ff.blue) ? rd_data_ff.blue - px_ff.blue
                                           : px_ff.blue - rd_data_ff.blue;
   end

   always_ff @(posedge clock) begin
      sq_r_ff   <= SQ_WIDTH'(dr) * SQ_WIDTH'(dr);
      sq_g_ff   <= SQ_WIDTH'(dg) * SQ_WIDTH'(dg);
      sq_b_ff   <= SQ_WIDTH'(db) * SQ_WIDTH'(db);
      color2_ff <= rd_data_ff;
      idx2_ff   <= idx1_ff;
      l2_ff     <= l1_ff;
      idx1_ff   <= rd_cnt_ff;
      l1_ff     <= (rd_cnt_ff == last_ff);
   end

   assign cand_dist = DIST_WIDTH'(sq_r_ff) + DIST_WIDTH'(sq_g_ff) + DIST_WIDTH'(sq_b_ff);

   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      rd_cnt_in     = rd_cnt_ff;
      last_in       = last_ff;
      first_in      = first_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      best_color_in = best_color_ff;
      rsp_load      = 1'b0;

      // compare stage
      if (v2_ff && (first_ff || cand_dist < best_dist_ff)) begin
         first_in      = 1'b0;
         best_dist_in  = cand_dist;
         best_idx_in   = idx2_ff;
         best_color_in = color2_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_opcode == OP_QUANTIZE) begin
               px_in     = color_type'({req_red, req_green, req_blue});
               rd_cnt_in = '0;
               last_in   = INDEX_WIDTH'(active_n - COUNT_WIDTH'(1));
               first_in  = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_cnt_in = rd_cnt_ff + INDEX_WIDTH'(1);
            if (rd_cnt_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (v2_ff && l2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= (state_ff == ST_SCAN);
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      rd_cnt_ff     <= rd_cnt_in;
      last_ff       <= last_in;
      first_ff      <= first_in;
      best_dist_ff  <= best_dist_in;
      best_idx_ff   <= best_idx_in;
      best_color_ff <= best_color_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_best_index <= best_idx_ff;
         rsp_out_red    <= best_color_ff.red;
         rsp_out_green  <= best_color_ff.green;
         rsp_out_blue   <= best_color_ff.blue;
         rsp_err_red    <= {1'b0, px_ff.red} - {1'b0, best_color_ff.red};
         rsp_err_green  <= {1'b0, px_ff.green} - {1'b0, best_color_ff.green};
         rsp_err_blue   <= {1'b0, px_ff.blue} - {1'b0, best_color_ff.blue};
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/pncq_checker.sv]
// port-level checks for the palette nearest color quantizer, bound to the top level
module pncq_checker
   import pncq_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_opcode,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [INDEX_WIDTH-1:0]      rsp_best_index,
   input logic signed [ERR_WIDTH-1:0] rsp_err_red,
   input logic signed [ERR_WIDTH-1:0] rsp_err_green,
   input logic signed [ERR_WIDTH-1:0] rsp_err_blue
);

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_best_index) &&
         $stable(rsp_err_red) && $stable(rsp_err_green) && $stable(rsp_err_blue)))
      else $error("stalled response changed");

   // a quantize transaction occupies the block
   a_quant_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_QUANTIZE) |=> req_stall)
      else $error("request taken during a search");

   // a load leaves the block free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_LOAD) |=> !req_stall)
      else $error("load stalled the next request");

   // a new response appears only at the end of a search
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a search");

endmodule

bind palette_nearest_color_quantizer pncq_checker u_pncq_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the palette nearest color quantizer
module testbench;
   import pncq_pkg::*;

   localparam int PALETTE_LIMIT = (PALETTE_ENTRIES_DEFAULT < INDEX_SLOTS) ?
                                  PALETTE_ENTRIES_DEFAULT : INDEX_SLOTS;
   localparam int unsigned FAR_DIST = 10000000;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_START = 1500;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 70;
   localparam int MAX_REPORTS = 40;
   localparam int DIRECTED_ROWS = 21;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]      best_index;
      color_type                   color;
      logic signed [ERR_WIDTH-1:0] err_red;
      logic signed [ERR_WIDTH-1:0] err_green;
      logic signed [ERR_WIDTH-1:0] err_blue;
   } quant_result_type;

   typedef struct packed {
      row_kind_type                kind;
      logic                        opcode;
      logic [INDEX_WIDTH-1:0]      entry_index;
      logic [CHAN_WIDTH-1:0]       red;
      logic [CHAN_WIDTH-1:0]       green;
      logic [CHAN_WIDTH-1:0]       blue;
      logic [COUNT_WIDTH-1:0]      csr_value;
      logic                        checked;
      logic [INDEX_WIDTH-1:0]      exp_index;
      logic [CHAN_WIDTH-1:0]       exp_red;
      logic [CHAN_WIDTH-1:0]       exp_green;
      logic [CHAN_WIDTH-1:0]       exp_blue;
      logic signed [ERR_WIDTH-1:0] exp_err_red;
      logic signed [ERR_WIDTH-1:0] exp_err_green;
      logic signed [ERR_WIDTH-1:0] exp_err_blue;
   } directed_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = OP_LOAD;
   logic [INDEX_WIDTH-1:0]      req_entry_index = '0;
   logic [CHAN_WIDTH-1:0]       req_red = '0;
   logic [CHAN_WIDTH-1:0]       req_green = '0;
   logic [CHAN_WIDTH-1:0]       req_blue = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [INDEX_WIDTH-1:0]      rsp_best_index;
   logic [CHAN_WIDTH-1:0]       rsp_out_red;
   logic [CHAN_WIDTH-1:0]       rsp_out_green;
   logic [CHAN_WIDTH-1:0]       rsp_out_blue;
   logic signed [ERR_WIDTH-1:0] rsp_err_red;
   logic signed [ERR_WIDTH-1:0] rsp_err_green;
   logic signed [ERR_WIDTH-1:0] rsp_err_blue;
   logic                        csr_wr_en = 1'b0;
   logic [COUNT_WIDTH-1:0]      csr_wr_data = '0;

   color_type              palette_mirror [INDEX_SLOTS];
   bit                     loaded [INDEX_SLOTS];
   logic [COUNT_WIDTH-1:0] count_mirror = 7'd1;
   quant_result_type       pending_results [$];
   int                     mismatch_count = 0;
   int                     quiet_cycles = 0;
   int                     burst_left = 0;
   bit                     gapless = 1'b0;
   logic [COUNT_WIDTH-1:0] count_plan [RANDOM_PHASES] = '{127, 64, 0, 3, 65, 1, 16, 0, 2, 0};

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_REQ, OP_LOAD,      0,   0,   0,   0, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_QUANTIZE,  0,   0,   0,   0, 0, 1, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_QUANTIZE,  0, 255, 255, 255, 0, 1, 0,   0,   0,   0,  255,  255,  255},
      '{ROW_REQ, OP_LOAD,      0, 255, 255, 255, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_QUANTIZE,  0,   0,   0,   0, 0, 1, 0, 255, 255, 255, -255, -255, -255},
      '{ROW_REQ, OP_QUANTIZE,  0, 255,   0, 255, 0, 1, 0, 255, 255, 255,    0, -255,    0},
      '{ROW_REQ, OP_LOAD,     63,  85, 170,  15, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_LOAD,      1, 255, 255, 255, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_LOAD,      2,   0,   0,   0, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_LOAD,      3, 128, 128, 128, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_CSR, OP_LOAD,      0,   0,   0,   0, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_QUANTIZE,  0, 255, 255, 255, 0, 1, 0, 255, 255, 255,    0,    0,    0},
      '{ROW_CSR, OP_LOAD,      0,   0,   0,   0, 2, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_QUANTIZE,  0, 200, 200, 200, 0, 1, 0, 255, 255, 255,  -55,  -55,  -55},
      '{ROW_CSR, OP_LOAD,      0,   0,   0,   0, 4, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_QUANTIZE,  0,  64,  64,  64, 0, 1, 2,   0,   0,   0,   64,   64,   64},
      '{ROW_REQ, OP_QUANTIZE,  0,  65,  65,  65, 0, 1, 3, 128, 128, 128,  -63,  -63,  -63},
      '{ROW_REQ, OP_QUANTIZE, 45,  10, 250, 120, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_LOAD,      2, 128, 128, 128, 0, 0, 0,   0,   0,   0,    0,    0,    0},
      '{ROW_REQ, OP_QUANTIZE,  0, 130, 120, 128, 0, 1, 2, 128, 128, 128,    2,   -8,    0},
      '{ROW_REQ, OP_QUANTIZE, 63, 255, 255, 255, 0, 1, 0, 255, 255, 255,    0,    0,    0}
   };

   palette_nearest_color_quantizer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_best_index  (rsp_best_index),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_err_red     (rsp_err_red),
      .rsp_err_green   (rsp_err_green),
      .rsp_err_blue    (rsp_err_blue),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_count();
      int n;
      n = int'(count_mirror);
      if (n < 1) n = 1;
      if (n > PALETTE_LIMIT) n = PALETTE_LIMIT;
      return n;
   endfunction

   function automatic int unsigned chan_sq(logic [CHAN_WIDTH-1:0] a, logic [CHAN_WIDTH-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   function automatic quant_result_type nearest_color(color_type px);
      quant_result_type res;
      int unsigned      cand_dist;
      int unsigned      best_dist;
      int               best;
      int               i;
      best = 0;
      best_dist = FAR_DIST;
      for (i = 0; i < active_count(); i++) begin
         cand_dist = chan_sq(palette_mirror[i].red, px.red)
                   + chan_sq(palette_mirror[i].green, px.green)
                   + chan_sq(palette_mirror[i].blue, px.blue);
         if (cand_dist < best_dist) begin
            best_dist = cand_dist;
            best = i;
         end
      end
      res.best_index = INDEX_WIDTH'(best);
      res.color = palette_mirror[best];
      res.err_red = ERR_WIDTH'(int'(px.red) - int'(palette_mirror[best].red));
      res.err_green = ERR_WIDTH'(int'(px.green) - int'(palette_mirror[best].green));
      res.err_blue = ERR_WIDTH'(int'(px.blue) - int'(palette_mirror[best].blue));
      return res;
   endfunction

   function automatic logic [CHAN_WIDTH-1:0] coarse_level();
      case ($urandom_range(0, 2))
         0: return 8'd0;
         1: return 8'd128;
         default: return 8'd255;
      endcase
   endfunction

   function automatic logic [CHAN_WIDTH-1:0] nudge(logic [CHAN_WIDTH-1:0] v);
      int t;
      t = int'(v) + int'($urandom_range(0, 8)) - 4;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return CHAN_WIDTH'(t);
   endfunction

   // coarse levels and copies of live entries make equal-distance ties common
   function automatic color_type random_palette_color();
      color_type c;
      int        sel;
      int        src;
      sel = $urandom_range(0, 3);
      src = $urandom_range(0, active_count() - 1);
      c.red = CHAN_WIDTH'($urandom);
      c.green = CHAN_WIDTH'($urandom);
      c.blue = CHAN_WIDTH'($urandom);
      if (sel == 0) begin
         c.red = coarse_level();
         c.green = coarse_level();
         c.blue = coarse_level();
      end else if (sel == 1 && loaded[src]) begin
         c = palette_mirror[src];
      end
      return c;
   endfunction

   function automatic color_type random_pixel();
      color_type c;
      int        sel;
      int        src;
      sel = $urandom_range(0, 3);
      src = $urandom_range(0, active_count() - 1);
      c.red = CHAN_WIDTH'($urandom);
      c.green = CHAN_WIDTH'($urandom);
      c.blue = CHAN_WIDTH'($urandom);
      if (sel == 0) begin
         c.red = coarse_level();
         c.green = coarse_level();
         c.blue = coarse_level();
      end else if (sel == 1) begin
         c.red = nudge(palette_mirror[src].red);
         c.green = nudge(palette_mirror[src].green);
         c.blue = nudge(palette_mirror[src].blue);
      end
      return c;
   endfunction

   task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // one transaction; the mirror follows the block at the accepting edge
   task automatic send_req(logic op, logic [INDEX_WIDTH-1:0] idx, color_type px,
                           logic use_typed, quant_result_type typed_result);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entry_index <= idx;
      req_red <= px.red;
      req_green <= px.green;
      req_blue <= px.blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) begin
         if (int'(idx) < PALETTE_ENTRIES_DEFAULT) begin
            palette_mirror[idx] = px;
            loaded[idx] = 1'b1;
         end
      end else begin
         pending_results.push_back(use_typed ? typed_result : nearest_color(px));
      end
   endtask

   task automatic pace_sender();
      int gap;
      int sel;
      if (gapless) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 11);
      sel = $urandom_range(0, 9);
      if (sel < 7) gap = $urandom_range(1, 5);
      else if (sel < 9) gap = $urandom_range(10, 40);
      else gap = $urandom_range(50, 90);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic write_palette_count(logic [COUNT_WIDTH-1:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      count_mirror = value;
   endtask

   always @(posedge clock) begin : result_check
      quant_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t unexpected transaction: expected none, actual index %0d",
                        $time, rsp_best_index);
         end else begin
            want = pending_results.pop_front();
            check_field("best_index", want.best_index, rsp_best_index);
            check_field("out_red", want.color.red, rsp_out_red);
            check_field("out_green", want.color.green, rsp_out_green);
            check_field("out_blue", want.color.blue, rsp_out_blue);
            check_field("err_red", want.err_red, rsp_err_red);
            check_field("err_green", want.err_green, rsp_err_green);
            check_field("err_blue", want.err_blue, rsp_err_blue);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // long hold-off once, so the block fills up and stalls its input
   initial begin : receiver
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         if (!reset) cyc++;
         if (reset) begin
            rsp_stall <= 1'b0;
         end else if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
         end else begin
            case ((cyc / 211) % 4)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 0);
               2: rsp_stall <= (cyc % 5 != 0);
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   initial begin : stimulus
      directed_row_type row;
      quant_result_type typed_result;
      color_type        px;
      logic             op;
      logic [INDEX_WIDTH-1:0] idx;
      int               phase;
      int               k;
      int               n;
      int               hole;
      int               i;
      int               r;
      count_plan[7] = COUNT_WIDTH'($urandom_range(0, 127));
      count_plan[9] = COUNT_WIDTH'($urandom_range(0, 127));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR) begin
            write_palette_count(row.csr_value);
         end else begin
            px.red = row.red;
            px.green = row.green;
            px.blue = row.blue;
            typed_result.best_index = row.exp_index;
            typed_result.color.red = row.exp_red;
            typed_result.color.green = row.exp_green;
            typed_result.color.blue = row.exp_blue;
            typed_result.err_red = row.exp_err_red;
            typed_result.err_green = row.exp_err_green;
            typed_result.err_blue = row.exp_err_blue;
            send_req(row.opcode, row.entry_index, px, row.checked, typed_result);
            pace_sender();
         end
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_palette_count(count_plan[phase]);
         gapless = (phase % 4 == 3);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            n = active_count();
            hole = -1;
            for (i = n - 1; i >= 0; i--) if (!loaded[i]) hole = i;
            op = ($urandom_range(0, 99) < 60) ? OP_QUANTIZE : OP_LOAD;
            idx = INDEX_WIDTH'($urandom_range(0, INDEX_SLOTS - 1));
            // a search may only cover slots that were loaded since reset
            if (op == OP_QUANTIZE && hole >= 0) begin
               op = OP_LOAD;
               idx = INDEX_WIDTH'(hole);
            end else if (op == OP_LOAD && $urandom_range(0, 3) != 0) begin
               idx = INDEX_WIDTH'($urandom_range(0, n - 1));
            end
            px = (op == OP_LOAD) ? random_palette_color() : random_pixel();
            send_req(op, idx, px, 1'b0, '0);
            pace_sender();
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
